// File: design/ihex_pkg.sv
package ihex_pkg;

    localparam logic [7:0] CharColon   = 8'h3A;
    localparam logic [7:0] CharNewline = 8'h0A;
    localparam logic [7:0] CharZero    = 8'h30;
    localparam logic [7:0] CharNine    = 8'h39;
    localparam logic [7:0] CharUpperA  = 8'h41;
    localparam logic [7:0] CharUpperF  = 8'h46;
    localparam logic [7:0] CharLowerA  = 8'h61;
    localparam logic [7:0] CharLowerF  = 8'h66;
    localparam logic [7:0] HexTen      = 8'd10;
    localparam logic [4:0] BadNib      = 5'd16;

    localparam logic [2:0] NeedByte = 3'd2;
    localparam logic [2:0] NeedWord = 3'd4;

    localparam logic [7:0] TypeData = 8'd0;
    localparam logic [7:0] TypeEof  = 8'd1;
    localparam logic [7:0] TypeExt  = 8'd4;

    localparam logic [1:0] RegFlashOffset  = 2'd0;
    localparam logic [1:0] RegSegAddress   = 2'd1;
    localparam logic [1:0] RegSegTarget    = 2'd2;
    localparam logic [1:0] RegTargetGiven  = 2'd3;

    typedef enum logic [6:0] {
        PH_WAIT = 7'b0000001,
        PH_SKIP = 7'b0000010,
        PH_LEN  = 7'b0000100,
        PH_ADDR = 7'b0001000,
        PH_TYPE = 7'b0010000,
        PH_DATA = 7'b0100000,
        PH_EXT  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [31:0] flash_offset;
        logic [31:0] seg_address;
        logic [31:0] seg_target;
        logic        target_given;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] byte_address;
        logic [7:0]  byte_value;
        logic        bad_digit;
        logic        end_of_file;
    } result_t;

    function automatic logic [4:0] nib_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= CharZero && c <= CharNine) begin
            t = c - CharZero;
        end
        else if (c >= CharUpperA && c <= CharUpperF) begin
            t = c - CharUpperA + HexTen;
        end
        else if (c >= CharLowerA && c <= CharLowerF) begin
            t = c - CharLowerA + HexTen;
        end
        else begin
            t = {3'd0, BadNib};
        end
        return t[4:0];
    endfunction

endpackage

// File: design/ihex_core.sv
module ihex_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        text_char,
    input  ihex_pkg::cfg_t    cfg,
    output ihex_pkg::result_t res
);

    ihex_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  count_reg, count_next;
    logic [15:0] accum_reg, accum_next;
    logic        frozen_reg, frozen_next;
    logic [7:0]  length_reg, length_next;
    logic [16:0] offset_reg, offset_next;
    logic [31:0] ext_reg, ext_next;
    logic [7:0]  index_reg, index_next;
    logic [4:0]  high_reg, high_next;
    logic        stopped_reg, stopped_next;
    logic [31:0] diff_reg;
    logic [31:0] base_reg;

    logic [4:0]  nib;
    logic        nib_bad;
    logic [15:0] tk_accum;
    logic        tk_frozen;
    logic [2:0]  tk_count;
    logic [2:0]  need;
    logic        field_done;
    logic [31:0] ext_word;
    logic [7:0]  index_inc;
    logic        suppress;

    assign nib      = ihex_pkg::nib_of(text_char);
    assign nib_bad  = nib[4];
    assign tk_count = count_reg + 3'd1;
    assign need     = (phase_reg == ihex_pkg::PH_ADDR || phase_reg == ihex_pkg::PH_EXT)
                      ? ihex_pkg::NeedWord : ihex_pkg::NeedByte;
    assign field_done = (tk_count >= need);
    assign ext_word   = {tk_accum, 16'd0};
    assign index_inc  = index_reg + 8'd1;
    assign suppress   = !cfg.target_given && (ext_reg == diff_reg);

    always_comb
    begin
        tk_accum  = accum_reg;
        tk_frozen = frozen_reg;
        if (!frozen_reg) begin
            tk_accum = {accum_reg[11:0], (nib_bad ? 4'd0 : nib[3:0])};
            tk_frozen = nib_bad;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        accum_next   = accum_reg;
        frozen_next  = frozen_reg;
        length_next  = length_reg;
        offset_next  = offset_reg;
        ext_next     = ext_reg;
        index_next   = index_reg;
        high_next    = high_reg;
        stopped_next = stopped_reg;
        res          = '0;

        if (step && !stopped_reg) begin
            if (text_char == ihex_pkg::CharNewline) begin
                phase_next  = ihex_pkg::PH_WAIT;
                count_next  = 3'd0;
                accum_next  = 16'd0;
                frozen_next = 1'b0;
                high_next   = 5'd0;
            end
            else begin
                unique case (phase_reg)
                    ihex_pkg::PH_WAIT:
                    begin
                        if (text_char == ihex_pkg::CharColon) begin
                            phase_next  = ihex_pkg::PH_LEN;
                            count_next  = 3'd0;
                            accum_next  = 16'd0;
                            frozen_next = 1'b0;
                        end
                        else begin
                            phase_next = ihex_pkg::PH_SKIP;
                        end
                    end
                    ihex_pkg::PH_SKIP:
                    begin
                    end
                    ihex_pkg::PH_LEN, ihex_pkg::PH_ADDR, ihex_pkg::PH_TYPE,
                    ihex_pkg::PH_EXT:
                    begin
                        accum_next  = tk_accum;
                        frozen_next = tk_frozen;
                        count_next  = tk_count;
                        if (field_done) begin
                            accum_next  = 16'd0;
                            frozen_next = 1'b0;
                            count_next  = 3'd0;
                            unique case (phase_reg)
                                ihex_pkg::PH_LEN:
                                begin
                                    length_next = tk_accum[7:0];
                                    phase_next  = ihex_pkg::PH_ADDR;
                                end
                                ihex_pkg::PH_ADDR:
                                begin
                                    offset_next = {1'b0, tk_accum};
                                    phase_next  = ihex_pkg::PH_TYPE;
                                end
                                ihex_pkg::PH_TYPE:
                                begin
                                    index_next = 8'd0;
                                    high_next  = 5'd0;
                                    phase_next = ihex_pkg::PH_SKIP;
                                    if (tk_accum[7:0] == ihex_pkg::TypeData) begin
                                        if (length_reg != 8'd0) begin
                                            phase_next = ihex_pkg::PH_DATA;
                                        end
                                    end
                                    else if (tk_accum[7:0] == ihex_pkg::TypeExt) begin
                                        phase_next = ihex_pkg::PH_EXT;
                                    end
                                    else if (tk_accum[7:0] == ihex_pkg::TypeEof) begin
                                        stopped_next    = 1'b1;
                                        res.valid       = 1'b1;
                                        res.end_of_file = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    ext_next   = (ext_word == cfg.seg_address)
                                                 ? diff_reg : ext_word;
                                    phase_next = ihex_pkg::PH_SKIP;
                                end
                            endcase
                        end
                    end
                    ihex_pkg::PH_DATA:
                    begin
                        if (!count_reg[0]) begin
                            high_next  = nib;
                            count_next = 3'd1;
                        end
                        else begin
                            count_next  = 3'd0;
                            high_next   = 5'd0;
                            index_next  = index_inc;
                            offset_next = offset_reg + 17'd1;
                            if (index_inc >= length_reg) begin
                                phase_next = ihex_pkg::PH_SKIP;
                            end
                            res.valid        = !suppress;
                            res.byte_address = base_reg + {15'd0, offset_reg};
                            if (high_reg[4]) begin
                                res.byte_value = 8'd0;
                                res.bad_digit  = 1'b1;
                            end
                            else if (nib_bad) begin
                                res.byte_value = {high_reg[3:0], 4'd0};
                                res.bad_digit  = 1'b1;
                            end
                            else begin
                                res.byte_value = {high_reg[3:0], nib[3:0]};
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= ihex_pkg::PH_WAIT;
            count_reg   <= 3'd0;
            accum_reg   <= 16'd0;
            frozen_reg  <= 1'b0;
            length_reg  <= 8'd0;
            offset_reg  <= 17'd0;
            ext_reg     <= 32'd0;
            index_reg   <= 8'd0;
            high_reg    <= 5'd0;
            stopped_reg <= 1'b0;
            diff_reg    <= 32'd0;
            base_reg    <= 32'd0;
        end
        else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            accum_reg   <= accum_next;
            frozen_reg  <= frozen_next;
            length_reg  <= length_next;
            offset_reg  <= offset_next;
            ext_reg     <= ext_next;
            index_reg   <= index_next;
            high_reg    <= high_next;
            stopped_reg <= stopped_next;
            diff_reg    <= cfg.seg_target - cfg.flash_offset;
            base_reg    <= cfg.flash_offset + ext_reg;
        end
    end

endmodule

// File: design/intel_hex_record_parser_remap.sv
// Intel HEX record parser with configuration-segment remapping.
// Characters of hex file text enter on the s_axis channel, one per item.
// Decoded data bytes and the end-of-file marker leave on the m_axis channel:
// tdata carries the target address and byte value, tuser the bad-digit and
// end-of-file flags. Non-record lines, checksums and other record types
// produce nothing; after the end-of-file record every character is dropped.
// Registers (flash offset, config segment address and target, target-given
// flag) are written through the cfg channel, which is always ready. The user
// must write them only while no item is in flight; the block itself does not
// enforce this. Each character is registered in the input register on
// acceptance and parsed from there, and its result is written to the output
// register. One character is taken every cycle while the receiver does not
// stall. While the receiver stalls, the output register holds its item and
// the input register holds one more character; s_axis_tready drops only when
// both are full. Reset returns the parser to the start of a line, clears the
// extended offset and loads the register defaults.
module intel_hex_record_parser_remap (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] byte_address, [39:32] byte_value
    output logic [1:0]  m_axis_tuser,   // [0] bad_digit, [1] end_of_file
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic              in_valid_reg;
    logic [7:0]        in_char_reg;
    logic              out_valid_reg, out_valid_next;
    logic [39:0]       out_data_reg;
    logic [1:0]        out_user_reg;
    ihex_pkg::cfg_t    cfg_reg;
    ihex_pkg::result_t res;
    logic              proc_fire;
    logic              in_fire;

    assign cfg_ready     = 1'b1;
    assign proc_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    ihex_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (proc_fire),
        .text_char (in_char_reg),
        .cfg       (cfg_reg),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc_fire && res.valid) begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.flash_offset <= 32'd0;
            cfg_reg.seg_address  <= 32'h0030_0000;
            cfg_reg.seg_target   <= 32'd0;
            cfg_reg.target_given <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            if (in_fire) begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    ihex_pkg::RegFlashOffset: cfg_reg.flash_offset <= cfg_data;
                    ihex_pkg::RegSegAddress:  cfg_reg.seg_address  <= cfg_data;
                    ihex_pkg::RegSegTarget:   cfg_reg.seg_target   <= cfg_data;
                    ihex_pkg::RegTargetGiven: cfg_reg.target_given <= cfg_data[0];
                    default:                  cfg_reg.target_given <= cfg_reg.target_given;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            in_char_reg <= s_axis_tdata;
        end
        if (proc_fire && res.valid) begin
            out_data_reg <= {res.byte_value, res.byte_address};
            out_user_reg <= {res.end_of_file, res.bad_digit};
        end
    end

    a_eof_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == 40'd0 && !m_axis_tuser[0]))
        else $error("end-of-file item carries nonzero payload");

    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    a_hold_char: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(in_char_reg)))
        else $error("pending character lost while stalled");

endmodule

// File: verif/tb_intel_hex_record_parser_remap.sv
module tb_intel_hex_record_parser_remap;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] byte_address;
        logic [7:0]  byte_value;
        logic        bad_digit;
        logic        end_of_file;
    } parsed_byte_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'h0;

    intel_hex_record_parser_remap dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // parser state as seen by the testbench
    logic [31:0] cfg_flash      = 32'h0;
    logic [31:0] cfg_seg_addr   = 32'h0030_0000;
    logic [31:0] cfg_seg_target = 32'h0;
    logic        cfg_given      = 1'b0;

    ihex_pkg::phase_t parse_state = ihex_pkg::PH_WAIT;
    logic [2:0]  dig_cnt     = 3'd0;
    logic [15:0] accum       = 16'h0;
    logic        frozen      = 1'b0;
    logic [7:0]  rec_len     = 8'h0;
    logic [15:0] rec_addr    = 16'h0;
    logic [7:0]  rec_type    = 8'h0;
    logic [31:0] ext_off     = 32'h0;
    logic [7:0]  byte_idx    = 8'h0;
    logic [4:0]  hi_nib      = 5'd0;
    logic        halted      = 1'b0;

    parsed_byte_t pending_bytes[$];
    logic [7:0]   text_queue[$];
    parsed_byte_t head;

    int   chars_pushed = 0;
    int   chars_taken  = 0;
    int   error_count  = 0;
    int   gap_pct      = 0;
    int   stall_pct    = 0;
    int   corrupt_pct  = 0;
    logic hold_off     = 1'b0;
    logic in_fire      = 1'b0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= ihex_pkg::CharZero && c <= ihex_pkg::CharNine)
        begin
            return 5'(c - ihex_pkg::CharZero);
        end
        if (c >= ihex_pkg::CharUpperA && c <= ihex_pkg::CharUpperF)
        begin
            return 5'(c - ihex_pkg::CharUpperA + ihex_pkg::HexTen);
        end
        if (c >= ihex_pkg::CharLowerA && c <= ihex_pkg::CharLowerF)
        begin
            return 5'(c - ihex_pkg::CharLowerA + ihex_pkg::HexTen);
        end
        return ihex_pkg::BadNib;
    endfunction

    function automatic logic take_digit(input logic [7:0] c, input logic [2:0] need,
                                        output logic [15:0] val);
        logic [4:0] d;
        d = hex_nibble(c);
        val = 16'h0;
        if (!frozen)
        begin
            accum = accum << 4;
            if (d == ihex_pkg::BadNib)
            begin
                frozen = 1'b1;
            end
            else
            begin
                accum = accum | {11'h0, d};
            end
        end
        dig_cnt = dig_cnt + 3'd1;
        if (dig_cnt < need)
        begin
            return 1'b0;
        end
        val = accum;
        accum = 16'h0;
        frozen = 1'b0;
        dig_cnt = 3'd0;
        return 1'b1;
    endfunction

    task automatic parse_char(input logic [7:0] c);
        logic [15:0]  v;
        logic [4:0]   d;
        logic [31:0]  e;
        logic [7:0]   idx;
        parsed_byte_t item;
        d = hex_nibble(c);
        item = '0;
        if (halted)
        begin
            return;
        end
        if (c == ihex_pkg::CharNewline)
        begin
            parse_state = ihex_pkg::PH_WAIT;
            dig_cnt = 3'd0;
            accum = 16'h0;
            frozen = 1'b0;
            hi_nib = 5'd0;
            return;
        end
        case (parse_state)
            ihex_pkg::PH_WAIT:
            begin
                if (c == ihex_pkg::CharColon)
                begin
                    parse_state = ihex_pkg::PH_LEN;
                    dig_cnt = 3'd0;
                    accum = 16'h0;
                    frozen = 1'b0;
                end
                else
                begin
                    parse_state = ihex_pkg::PH_SKIP;
                end
            end
            ihex_pkg::PH_LEN:
            begin
                if (take_digit(c, ihex_pkg::NeedByte, v))
                begin
                    rec_len = v[7:0];
                    parse_state = ihex_pkg::PH_ADDR;
                end
            end
            ihex_pkg::PH_ADDR:
            begin
                if (take_digit(c, ihex_pkg::NeedWord, v))
                begin
                    rec_addr = v;
                    parse_state = ihex_pkg::PH_TYPE;
                end
            end
            ihex_pkg::PH_TYPE:
            begin
                if (take_digit(c, ihex_pkg::NeedByte, v))
                begin
                    rec_type = v[7:0];
                    byte_idx = 8'h0;
                    hi_nib = 5'd0;
                    if (rec_type == ihex_pkg::TypeData)
                    begin
                        parse_state = (rec_len == 8'h0) ? ihex_pkg::PH_SKIP : ihex_pkg::PH_DATA;
                    end
                    else if (rec_type == ihex_pkg::TypeExt)
                    begin
                        parse_state = ihex_pkg::PH_EXT;
                    end
                    else if (rec_type == ihex_pkg::TypeEof)
                    begin
                        halted = 1'b1;
                        parse_state = ihex_pkg::PH_SKIP;
                        item.end_of_file = 1'b1;
                        pending_bytes.push_back(item);
                    end
                    else
                    begin
                        parse_state = ihex_pkg::PH_SKIP;
                    end
                end
            end
            ihex_pkg::PH_EXT:
            begin
                if (take_digit(c, ihex_pkg::NeedWord, v))
                begin
                    e = {v, 16'h0};
                    if (e == cfg_seg_addr)
                    begin
                        e = cfg_seg_target - cfg_flash;
                    end
                    ext_off = e;
                    parse_state = ihex_pkg::PH_SKIP;
                end
            end
            ihex_pkg::PH_DATA:
            begin
                if (dig_cnt == 3'd0)
                begin
                    hi_nib = d;
                    dig_cnt = 3'd1;
                end
                else
                begin
                    dig_cnt = 3'd0;
                    if (hi_nib == ihex_pkg::BadNib)
                    begin
                        item.byte_value = 8'h00;
                        item.bad_digit = 1'b1;
                    end
                    else if (d == ihex_pkg::BadNib)
                    begin
                        item.byte_value = {hi_nib[3:0], 4'h0};
                        item.bad_digit = 1'b1;
                    end
                    else
                    begin
                        item.byte_value = {hi_nib[3:0], d[3:0]};
                    end
                    hi_nib = 5'd0;
                    idx = byte_idx;
                    byte_idx = byte_idx + 8'd1;
                    if (byte_idx >= rec_len)
                    begin
                        parse_state = ihex_pkg::PH_SKIP;
                    end
                    // drop bytes of the config segment when no target was given
                    if (cfg_given || ext_off != cfg_seg_target - cfg_flash)
                    begin
                        item.byte_address = cfg_flash + ext_off + {16'h0, rec_addr}
                                            + {24'h0, idx};
                        pending_bytes.push_back(item);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // sample both channels
    always @(posedge clk)
    begin
        in_fire = s_axis_tvalid && s_axis_tready && rst_n;
        if (m_axis_tvalid && m_axis_tready && rst_n)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected item: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                head = pending_bytes.pop_front();
                if (m_axis_tdata[31:0] !== head.byte_address)
                begin
                    $error("byte_address: expected %h, actual %h",
                           head.byte_address, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[39:32] !== head.byte_value)
                begin
                    $error("byte_value: expected %h, actual %h",
                           head.byte_value, m_axis_tdata[39:32]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== head.bad_digit)
                begin
                    $error("bad_digit: expected %b, actual %b",
                           head.bad_digit, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tuser[1] !== head.end_of_file)
                begin
                    $error("end_of_file: expected %b, actual %b",
                           head.end_of_file, m_axis_tuser[1]);
                    error_count++;
                end
            end
        end
        if (in_fire)
        begin
            chars_taken++;
            parse_char(s_axis_tdata);
        end
    end

    // feed characters, hold each until taken
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || in_fire)
        begin
            if (text_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                s_axis_tdata <= text_queue.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic put_char(input logic [7:0] c);
        text_queue.push_back(c);
        chars_pushed++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            put_char(s[i]);
        end
    endtask

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom);
        end
        while (hex_nibble(c) != ihex_pkg::BadNib || c == ihex_pkg::CharNewline);
        return c;
    endfunction

    // emit one record line; digits may be corrupted and the line may be cut short
    task automatic put_record(input logic [7:0] len, input logic [15:0] addr,
                              input logic [7:0] rtype, input int ndig,
                              input logic [15:0] lead, input logic cut);
        logic [31:0] hdr;
        logic [3:0]  nibs[$];
        logic [7:0]  line[$];
        logic [7:0]  c;
        int          keep;
        hdr = {len, addr, rtype};
        for (int i = 7; i >= 0; i--)
        begin
            nibs.push_back(hdr[4 * i +: 4]);
        end
        for (int i = 0; i < ndig; i++)
        begin
            nibs.push_back((i < 4) ? lead[15 - 4 * i -: 4] : 4'($urandom));
        end
        repeat (2)
        begin
            nibs.push_back(4'($urandom));
        end
        line.push_back(ihex_pkg::CharColon);
        foreach (nibs[i])
        begin
            if (nibs[i] < 4'd10)
            begin
                c = 8'(ihex_pkg::CharZero + nibs[i]);
            end
            else
            begin
                c = 8'(($urandom_range(0, 1) ? ihex_pkg::CharUpperA : ihex_pkg::CharLowerA)
                       + nibs[i] - ihex_pkg::HexTen);
            end
            if (i < nibs.size() - 2 && $urandom_range(0, 99) < corrupt_pct)
            begin
                c = junk_char();
            end
            line.push_back(c);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            line.push_back(ihex_pkg::CharColon);
            repeat ($urandom_range(0, 10))
            begin
                line.push_back(8'(ihex_pkg::CharZero + $urandom_range(0, 9)));
            end
        end
        if (cut)
        begin
            keep = $urandom_range(1, line.size() - 1);
            while (line.size() > keep)
            begin
                void'(line.pop_back());
            end
        end
        foreach (line[i])
        begin
            put_char(line[i]);
        end
        put_char(ihex_pkg::CharNewline);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            ihex_pkg::RegFlashOffset: cfg_flash = val;
            ihex_pkg::RegSegAddress:  cfg_seg_addr = val;
            ihex_pkg::RegSegTarget:   cfg_seg_target = val;
            ihex_pkg::RegTargetGiven: cfg_given = val[0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait for every character to be taken and every byte to come out
    task automatic drain();
        while (chars_taken != chars_pushed)
        begin
            @(posedge clk);
        end
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int          phase_start;
        int          pick;
        int          ndig;
        logic [7:0]  len;
        logic [7:0]  rtype;
        logic [7:0]  c;
        logic [15:0] lead;
        logic [31:0] new_flash;
        logic [31:0] new_seg;
        logic [31:0] new_target;
        logic        new_given;

        rst_n = 1'b0;
        repeat (10)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;

        // register defaults: bytes at extended offset zero are dropped
        put_text(":0200000012AB41\n");
        put_text(":020000040001F9\n");
        put_text(":02FFFF00ff00aa\n");
        put_text("hello:0100\n");
        put_text(":03001000G12H3A5C\n");
        put_text(":1G002000AABB\n");
        put_text(":0112Z40066\n");
        put_text(":0100000Q5A\n");
        put_text(":0200000512345678\n");
        put_text(":020000021000EC\n");
        put_text(":02000004003\n");
        put_text(":0200000412X4\n");
        put_text(":01000100EE\n");
        put_text(":020000040030CA\n");
        put_text(":01000000AA\n");
        put_text(":0200000400FF:01000000AA\n");
        put_text(":0100050011\n");
        put_text(":00000000\n");
        put_text(":01000600223344\n");
        put_text(":03000700123\n");
        put_text(":01000800AB\r\n");
        put_text(":FF12340011223344\n");
        drain();

        corrupt_pct = 3;
        for (int p = 1; p <= 8; p++)
        begin
            case (p)
                1:
                begin
                    new_flash = $urandom;
                    new_seg = {16'($urandom), 16'h0};
                    new_target = $urandom;
                    new_given = 1'b1;
                end
                2:
                begin
                    new_flash = 32'hFFFF_FFFF;
                    new_seg = 32'hFFFF_0000;
                    new_target = 32'hFFFF_FFFF;
                    new_given = 1'b1;
                end
                3:
                begin
                    new_flash = 32'h0;
                    new_seg = 32'h0;
                    new_target = 32'h0;
                    new_given = 1'b0;
                end
                default:
                begin
                    new_flash = $urandom;
                    new_seg = ($urandom_range(0, 3) == 0) ? $urandom : {16'($urandom), 16'h0};
                    new_target = $urandom;
                    new_given = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(ihex_pkg::RegFlashOffset, new_flash);
            write_reg(ihex_pkg::RegSegAddress, new_seg);
            write_reg(ihex_pkg::RegSegTarget, new_target);
            write_reg(ihex_pkg::RegTargetGiven, {31'h0, new_given});

            case ((p - 1) % 4)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 77;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 77;
                end
                default:
                begin
                    gap_pct = 27;
                    stall_pct = 27;
                end
            endcase

            // hold the receiver off so the block backs up onto its input
            if (p == 1)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400)
                        begin
                            @(posedge clk);
                        end
                        hold_off = 1'b0;
                    end
                join_none
            end

            phase_start = chars_pushed;
            while (chars_pushed - phase_start < 120)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    pick = $urandom_range(0, 299);
                    len = (pick == 0) ? 8'hFF :
                          (pick < 10) ? 8'h00 : 8'($urandom_range(1, 16));
                    ndig = 2 * len;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        ndig = ndig + $urandom_range(1, 3);
                    end
                    put_record(len, ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom),
                               ihex_pkg::TypeData, ndig, 16'($urandom),
                               $urandom_range(0, 9) == 0);
                end
                else if (pick < 75)
                begin
                    case ($urandom_range(0, 3))
                        0: lead = cfg_seg_addr[31:16];
                        1: lead = 16'h0000;
                        2: lead = 16'hFFFF;
                        default: lead = 16'($urandom);
                    endcase
                    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
                    put_record(8'h02, 16'($urandom), ihex_pkg::TypeExt, ndig, lead,
                               $urandom_range(0, 9) == 0);
                end
                else if (pick < 85)
                begin
                    rtype = 8'($urandom_range(2, 255));
                    if (rtype == ihex_pkg::TypeExt)
                    begin
                        rtype = 8'h03;
                    end
                    put_record(8'($urandom_range(0, 4)), 16'($urandom), rtype, 4,
                               16'($urandom), $urandom_range(0, 9) == 0);
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    put_char(ihex_pkg::CharNewline);
                end
                else
                begin
                    do
                    begin
                        c = 8'($urandom);
                    end
                    while (c == ihex_pkg::CharColon || c == ihex_pkg::CharNewline);
                    put_char(c);
                    repeat ($urandom_range(0, 20))
                    begin
                        do
                        begin
                            c = 8'($urandom);
                        end
                        while (c == ihex_pkg::CharNewline);
                        put_char(c);
                    end
                    put_char(ihex_pkg::CharNewline);
                end
            end
            drain();
        end

        // end record, then text that must be ignored
        gap_pct = 0;
        stall_pct = 0;
        put_text(":00000001FF\n");
        put_text(":0100000055\n");
        put_text(":020000040001F9\n:0200000011223344\n");
        drain();

        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: intel_hex_record_parser_remap.f
design/ihex_pkg.sv
design/ihex_core.sv
design/intel_hex_record_parser_remap.sv
verif/tb_intel_hex_record_parser_remap.sv
